/* hw/rtl/oae_pkg.sv */
// Shared types, operation and status codes for the ordered array engine.
package oae_pkg;

    localparam int CAPACITY_DEF = 128;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_SEARCH = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [7:0]         position;
        logic signed [31:0] data_value;
        logic signed [31:0] search_key;
    } in_beat_t;

    typedef struct packed {
        status_t            status;
        logic [7:0]         found_position;
        logic signed [31:0] read_value;
        logic [7:0]         element_count;
    } out_beat_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_UP,
        SH_DOWN
    } shift_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_CNT_M1,
        IDX_POS,
        IDX_POS_M1,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        logic    load;
        logic    rd;
        shift_t  shift;
        logic    wr_val;
        idx_op_t idx_op;
        cnt_op_t cnt_op;
        logic    finish;
        status_t status;
        logic    found_en;
        logic    read_en;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       cnt_zero;
        logic       cnt_full;
        logic       pos_ok;
        logic       pos_ins_ok;
        logic       pos_eq_cnt;
        logic       idx_eq_posm1;
        logic       idx_eq_cntm1;
        logic       idx_lt_cnt;
        logic       hit;
        logic       rd_valid;
        logic       out_busy;
    } dp_stat_t;

endpackage

/* hw/rtl/oae_datapath.sv */
// Datapath of the ordered array engine: entry memory, count, index and result register.
module oae_datapath
    import oae_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_beat_t  s_data,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = ((CW > 8) ? CW : 8) + 1;

    logic [31:0]        mem [CAPACITY];

    logic [2:0]         op_reg;
    logic [7:0]         pos_reg;
    logic signed [31:0] val_reg;
    logic signed [31:0] key_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      idx_next;
    logic [31:0]        rdata_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic               rd_valid_reg;
    logic               pend_reg;
    logic [AW-1:0]      wr_addr_reg;
    logic               m_valid_reg;
    out_beat_t          m_data_reg;

    logic [EW-1:0]      pos_ext;
    logic [EW-1:0]      cnt_ext;
    logic [EW-1:0]      idx_ext;
    logic [AW-1:0]      rd_addr;

    assign pos_ext = EW'(pos_reg);
    assign cnt_ext = EW'(count_reg);
    assign idx_ext = EW'(idx_reg);
    assign rd_addr = idx_reg[AW-1:0];

    always_comb begin
        stat.op           = op_reg;
        stat.cnt_zero     = (count_reg == '0);
        stat.cnt_full     = (count_reg == CW'(CAPACITY));
        stat.pos_ok       = (pos_reg != '0) && (pos_ext <= cnt_ext);
        stat.pos_ins_ok   = (pos_reg != '0) && (pos_ext <= cnt_ext + EW'(1));
        stat.pos_eq_cnt   = (pos_ext == cnt_ext);
        stat.idx_eq_posm1 = (idx_ext + EW'(1) == pos_ext);
        stat.idx_eq_cntm1 = (idx_ext + EW'(1) == cnt_ext);
        stat.idx_lt_cnt   = (idx_reg < count_reg);
        stat.hit          = rd_valid_reg && (rdata_reg == key_reg);
        stat.rd_valid     = rd_valid_reg;
        stat.out_busy     = m_valid_reg && !m_ready;
    end

    always_comb begin
        case (cmd.idx_op)
            IDX_HOLD:   idx_next = idx_reg;
            IDX_ZERO:   idx_next = '0;
            IDX_CNT_M1: idx_next = count_reg - CW'(1);
            IDX_POS:    idx_next = CW'(pos_reg);
            IDX_POS_M1: idx_next = CW'(pos_ext - EW'(1));
            IDX_INC:    idx_next = idx_reg + CW'(1);
            IDX_DEC:    idx_next = idx_reg - CW'(1);
            default:    idx_next = idx_reg;
        endcase
        case (cmd.cnt_op)
            CNT_HOLD:  count_next = count_reg;
            CNT_CLEAR: count_next = '0;
            CNT_INC:   count_next = count_reg + CW'(1);
            CNT_DEC:   count_next = count_reg - CW'(1);
            default:   count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            mem[wr_addr_reg] <= rdata_reg;
        end else if (cmd.wr_val) begin
            mem[rd_addr] <= val_reg;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_data.operation;
            pos_reg <= s_data.position;
            val_reg <= s_data.data_value;
            key_reg <= s_data.search_key;
        end
        idx_reg <= idx_next;
        if (cmd.rd) begin
            rd_addr_reg <= rd_addr;
            if (cmd.shift == SH_UP) begin
                wr_addr_reg <= AW'(idx_reg + CW'(1));
            end else begin
                wr_addr_reg <= AW'(idx_reg - CW'(1));
            end
        end
        if (cmd.finish) begin
            m_data_reg.status         <= cmd.status;
            m_data_reg.found_position <= cmd.found_en ?
                                         8'(EW'(rd_addr_reg) + EW'(1)) : 8'd0;
            m_data_reg.read_value     <= cmd.read_en ? rdata_reg : 32'sd0;
            m_data_reg.element_count  <= 8'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            rd_valid_reg <= cmd.rd;
            pend_reg     <= cmd.rd && (cmd.shift != SH_NONE);
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hw/rtl/oae_controller.sv */
// Sequencing state machine of the ordered array engine.
module oae_controller
    import oae_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_DRAIN_UP,
        S_INS_WR,
        S_SHIFT_DN,
        S_DRAIN_DN,
        S_SEARCH,
        S_READ,
        S_RESP
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    status_t res_status_reg;
    status_t res_status_next;
    logic    res_found_reg;
    logic    res_found_next;
    logic    res_read_reg;
    logic    res_read_next;

    always_comb begin
        cmd             = '0;
        cmd.shift       = SH_NONE;
        cmd.idx_op      = IDX_HOLD;
        cmd.cnt_op      = CNT_HOLD;
        cmd.status      = res_status_reg;
        cmd.found_en    = res_found_reg;
        cmd.read_en     = res_read_reg;
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_read_next   = res_read_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_status_next = ST_OK;
                res_found_next  = 1'b0;
                res_read_next   = 1'b0;
                state_next      = S_RESP;
                case (stat.op)
                    OP_CLEAR: begin
                        cmd.cnt_op = CNT_CLEAR;
                    end
                    OP_INSERT: begin
                        if (stat.cnt_full) begin
                            res_status_next = ST_FULL;
                        end else if (!stat.pos_ins_ok) begin
                            res_status_next = ST_BADPOS;
                        end else if (stat.pos_ok) begin
                            cmd.idx_op = IDX_CNT_M1;
                            state_next = S_SHIFT_UP;
                        end else begin
                            cmd.idx_op = IDX_POS_M1;
                            state_next = S_INS_WR;
                        end
                    end
                    OP_DELETE: begin
                        if (stat.cnt_zero) begin
                            res_status_next = ST_EMPTY;
                        end else if (!stat.pos_ok) begin
                            res_status_next = ST_BADPOS;
                        end else if (stat.pos_eq_cnt) begin
                            cmd.cnt_op = CNT_DEC;
                        end else begin
                            cmd.idx_op = IDX_POS;
                            state_next = S_SHIFT_DN;
                        end
                    end
                    OP_SEARCH: begin
                        cmd.idx_op = IDX_ZERO;
                        state_next = S_SEARCH;
                    end
                    OP_READ: begin
                        if (stat.cnt_zero) begin
                            res_status_next = ST_EMPTY;
                        end else if (!stat.pos_ok) begin
                            res_status_next = ST_BADPOS;
                        end else begin
                            cmd.idx_op    = IDX_POS_M1;
                            res_read_next = 1'b1;
                            state_next    = S_READ;
                        end
                    end
                    default: begin
                        res_status_next = ST_BADPOS;
                    end
                endcase
            end
            S_SHIFT_UP: begin
                cmd.rd    = 1'b1;
                cmd.shift = SH_UP;
                if (stat.idx_eq_posm1) begin
                    state_next = S_DRAIN_UP;
                end else begin
                    cmd.idx_op = IDX_DEC;
                end
            end
            S_DRAIN_UP: begin
                state_next = S_INS_WR;
            end
            S_INS_WR: begin
                cmd.wr_val = 1'b1;
                cmd.cnt_op = CNT_INC;
                state_next = S_RESP;
            end
            S_SHIFT_DN: begin
                cmd.rd    = 1'b1;
                cmd.shift = SH_DOWN;
                if (stat.idx_eq_cntm1) begin
                    state_next = S_DRAIN_DN;
                end else begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_DRAIN_DN: begin
                cmd.cnt_op = CNT_DEC;
                state_next = S_RESP;
            end
            S_SEARCH: begin
                if (stat.hit) begin
                    res_status_next = ST_OK;
                    res_found_next  = 1'b1;
                    state_next      = S_RESP;
                end else if (stat.idx_lt_cnt) begin
                    cmd.rd     = 1'b1;
                    cmd.idx_op = IDX_INC;
                end else if (!stat.rd_valid) begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_RESP;
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            res_status_reg <= ST_OK;
            res_found_reg  <= 1'b0;
            res_read_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_found_reg  <= res_found_next;
            res_read_reg   <= res_read_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

/* hw/rtl/ordered_array_engine.sv */
// Top level of the ordered array engine.
// The block keeps a dense ordered array of signed 32-bit words and a count.
// Requests arrive as beats on the s_ channel (valid/ready); each beat holds an
// operation (clear, insert, delete, search, read), a 1-based position, a word to
// insert and a search key. Every request yields exactly one result beat on the
// m_ channel with a status, the found position, the read word and the count.
// One request is processed at a time. Clear, rejected requests and a delete of the last
// entry finish without touching the memory, and a read or an insert at the end needs a
// single memory access. Any other insert moves the entries from the last one down to the
// position up by one, one entry at a time, before it writes the new word, and delete moves
// the entries above the position down by one. Search reads the entries in order from the
// first until a hit or the end of the array; an empty array is a miss at once.
// A finished result sits in an output register, so the next request is taken
// as soon as the sequencer is free; if the receiver stalls with a result still
// pending, the next request runs and waits in its final state.
// Synchronous reset empties the array and drops any pending result; memory
// contents are not cleared and are never read before being written.
module ordered_array_engine
    import oae_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    oae_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    oae_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* sim/ordered_array_engine_tb.sv */
// Self-checking bench: a directed table, then random requests checked against a predictor.
`timescale 1ns / 100ps

module ordered_array_engine_tb;
    import oae_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 830;
    localparam int CALM_ITEMS   = 100;
    localparam int HOLD_AT      = 200;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = CAPACITY + 20;
    localparam int CYCLE_LIMIT  = 800000;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID   = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED
    } mix_t;

    typedef struct packed {
        in_beat_t  req;
        logic      typed;
        out_beat_t want;
    } stim_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    logic signed [31:0] mirror_words [CAPACITY];
    int                 mirror_count = 0;
    out_beat_t          replies_due [$];

    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   stall_left = 0;
    logic hold_request = 1'b0;
    logic hold_done = 1'b0;
    logic calm_tail = 1'b0;

    ordered_array_engine dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    function automatic out_beat_t apply_array_op(in_beat_t req);
        out_beat_t rsp;
        int        pos;
        rsp = '0;
        rsp.status = ST_OK;
        pos = int'(req.position);
        case (req.operation)
            OP_CLEAR: begin
                mirror_count = 0;
            end
            OP_INSERT: begin
                if (mirror_count >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else if (pos < 1 || pos > mirror_count + 1) begin
                    rsp.status = ST_BADPOS;
                end else begin
                    for (int i = mirror_count; i >= pos; i--) begin
                        mirror_words[i] = mirror_words[i - 1];
                    end
                    mirror_words[pos - 1] = req.data_value;
                    mirror_count++;
                end
            end
            OP_DELETE: begin
                if (mirror_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (pos < 1 || pos > mirror_count) begin
                    rsp.status = ST_BADPOS;
                end else begin
                    for (int i = pos - 1; i + 1 < mirror_count; i++) begin
                        mirror_words[i] = mirror_words[i + 1];
                    end
                    mirror_count--;
                end
            end
            OP_SEARCH: begin
                rsp.status = ST_NOTFOUND;
                for (int i = 0; i < mirror_count; i++) begin
                    if (mirror_words[i] == req.search_key) begin
                        rsp.status = ST_OK;
                        rsp.found_position = 8'(i + 1);
                        break;
                    end
                end
            end
            OP_READ: begin
                if (mirror_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (pos < 1 || pos > mirror_count) begin
                    rsp.status = ST_BADPOS;
                end else begin
                    rsp.read_value = mirror_words[pos - 1];
                end
            end
            default: begin
                rsp.status = ST_BADPOS;
            end
        endcase
        rsp.element_count = 8'(mirror_count);
        return rsp;
    endfunction

    function automatic logic [7:0] pick_position(int valid_hi);
        int pick;
        if (valid_hi >= 1 && $urandom_range(99, 0) < 90) begin
            return 8'($urandom_range(valid_hi, 1));
        end
        pick = $urandom_range(2, 0);
        if (pick == 0) begin
            return 8'd0;
        end else if (pick == 1) begin
            return 8'((valid_hi + 1 > 255) ? 255 : valid_hi + 1);
        end
        return 8'($urandom_range(255, 0));
    endfunction

    function automatic in_beat_t make_request(mix_t mix);
        in_beat_t req;
        int       roll;
        int       w_ins;
        int       w_del;
        int       w_srch;
        int       w_rd;
        int       w_clr;
        case (mix)
            MIX_GROW: begin
                w_ins = 74; w_del = 8; w_srch = 10; w_rd = 7; w_clr = 0;
            end
            MIX_SHRINK: begin
                w_ins = 12; w_del = 60; w_srch = 12; w_rd = 12; w_clr = 2;
            end
            default: begin
                w_ins = 35; w_del = 25; w_srch = 20; w_rd = 15; w_clr = 3;
            end
        endcase
        req.position = 8'($urandom_range(255, 0));
        if ($urandom_range(3, 0) == 0) begin
            req.data_value = int'($urandom_range(7, 0)) - 4;
        end else begin
            req.data_value = $urandom;
        end
        if (mirror_count > 0 && $urandom_range(99, 0) < 65) begin
            req.search_key = mirror_words[$urandom_range(mirror_count - 1, 0)];
        end else if ($urandom_range(5, 0) == 0) begin
            req.search_key = int'($urandom_range(7, 0)) - 4;
        end else begin
            req.search_key = $urandom;
        end
        roll = $urandom_range(99, 0);
        if (roll < w_ins) begin
            req.operation = OP_INSERT;
            req.position = pick_position(mirror_count + 1);
        end else if (roll < w_ins + w_del) begin
            req.operation = OP_DELETE;
            req.position = pick_position(mirror_count);
        end else if (roll < w_ins + w_del + w_srch) begin
            req.operation = OP_SEARCH;
        end else if (roll < w_ins + w_del + w_srch + w_rd) begin
            req.operation = OP_READ;
            req.position = pick_position(mirror_count);
        end else if (roll < w_ins + w_del + w_srch + w_rd + w_clr) begin
            req.operation = OP_CLEAR;
        end else begin
            req.operation = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        end
        return req;
    endfunction

    function automatic stim_row_t fixed_row(logic [2:0] op, logic [7:0] pos,
                                            logic signed [31:0] val, logic signed [31:0] key,
                                            status_t st, logic signed [31:0] rd_word,
                                            logic [7:0] cnt);
        stim_row_t row;
        row.req = '{operation: op, position: pos, data_value: val, search_key: key};
        row.typed = 1'b1;
        row.want = '{status: st, found_position: 8'd0, read_value: rd_word,
                     element_count: cnt};
        return row;
    endfunction

    function automatic stim_row_t model_row(logic [2:0] op, logic [7:0] pos,
                                            logic signed [31:0] val, logic signed [31:0] key);
        stim_row_t row;
        row.req = '{operation: op, position: pos, data_value: val, search_key: key};
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    task automatic send_request(input in_beat_t req, input logic typed, input out_beat_t want,
                                input logic calm);
        int        gap;
        out_beat_t model_rsp;
        gap = 0;
        if (!calm && $urandom_range(3, 0) == 0) begin
            gap = $urandom_range(4, 1);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        model_rsp = apply_array_op(req);
        replies_due.push_back(typed ? want : model_rsp);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (hold_request && !hold_done) begin
            m_ready <= 1'b0;
            stall_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (!calm_tail && $urandom_range(5, 0) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(3, 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                mismatch_count++;
                $error("result beat with no request outstanding");
            end else begin
                want = replies_due.pop_front();
                if (m_data.status !== want.status) begin
                    mismatch_count++;
                    $error("status: expected %0d, actual %0d", want.status, m_data.status);
                end
                if (m_data.found_position !== want.found_position) begin
                    mismatch_count++;
                    $error("found_position: expected %0d, actual %0d",
                           want.found_position, m_data.found_position);
                end
                if (m_data.read_value !== want.read_value) begin
                    mismatch_count++;
                    $error("read_value: expected %0d, actual %0d",
                           want.read_value, m_data.read_value);
                end
                if (m_data.element_count !== want.element_count) begin
                    mismatch_count++;
                    $error("element_count: expected %0d, actual %0d",
                           want.element_count, m_data.element_count);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        stim_row_t directed_rows [$];
        mix_t      mix;
        logic      calm;

        directed_rows.push_back(fixed_row(OP_READ, 8'd1, 32'sd0, 32'sd0, ST_EMPTY, 32'sd0, 8'd0));
        directed_rows.push_back(fixed_row(OP_DELETE, 8'd1, 32'sd0, 32'sd0, ST_EMPTY, 32'sd0, 8'd0));
        directed_rows.push_back(fixed_row(OP_SEARCH, 8'd0, 32'sd0, 32'sd0, ST_NOTFOUND, 32'sd0,
                                          8'd0));
        directed_rows.push_back(fixed_row(OP_INSERT, 8'd0, 32'sd5, 32'sd0, ST_BADPOS, 32'sd0, 8'd0));
        directed_rows.push_back(fixed_row(OP_INSERT, 8'd2, 32'sd5, 32'sd0, ST_BADPOS, 32'sd0, 8'd0));
        directed_rows.push_back(fixed_row(OP_SPARE_FIRST, 8'd1, 32'sd0, 32'sd0, ST_BADPOS, 32'sd0,
                                          8'd0));
        directed_rows.push_back(fixed_row(OP_SPARE_LAST, 8'd255, -32'sd1, -32'sd1, ST_BADPOS,
                                          32'sd0, 8'd0));
        directed_rows.push_back(fixed_row(OP_INSERT, 8'd1, 32'h7FFF_FFFF, 32'sd0, ST_OK, 32'sd0,
                                          8'd1));
        directed_rows.push_back(fixed_row(OP_INSERT, 8'd1, 32'h8000_0000, 32'sd0, ST_OK, 32'sd0,
                                          8'd2));
        directed_rows.push_back(fixed_row(OP_INSERT, 8'd3, -32'sd1, 32'sd0, ST_OK, 32'sd0, 8'd3));
        directed_rows.push_back(fixed_row(OP_READ, 8'd1, 32'sd0, 32'sd0, ST_OK, 32'h8000_0000,
                                          8'd3));
        directed_rows.push_back(model_row(OP_READ, 8'd3, 32'sd0, 32'sd0));
        directed_rows.push_back(fixed_row(OP_READ, 8'd0, 32'sd0, 32'sd0, ST_BADPOS, 32'sd0, 8'd3));
        directed_rows.push_back(fixed_row(OP_READ, 8'd255, 32'sd0, 32'sd0, ST_BADPOS, 32'sd0,
                                          8'd3));
        directed_rows.push_back(model_row(OP_SEARCH, 8'd0, 32'sd0, 32'h7FFF_FFFF));
        directed_rows.push_back(fixed_row(OP_SEARCH, 8'd0, 32'sd0, 32'sd12345, ST_NOTFOUND,
                                          32'sd0, 8'd3));
        directed_rows.push_back(fixed_row(OP_INSERT, 8'd255, 32'sd7, 32'sd0, ST_BADPOS, 32'sd0,
                                          8'd3));
        directed_rows.push_back(fixed_row(OP_DELETE, 8'd0, 32'sd0, 32'sd0, ST_BADPOS, 32'sd0,
                                          8'd3));
        directed_rows.push_back(fixed_row(OP_DELETE, 8'd4, 32'sd0, 32'sd0, ST_BADPOS, 32'sd0,
                                          8'd3));
        directed_rows.push_back(model_row(OP_DELETE, 8'd2, 32'sd0, 32'sd0));
        directed_rows.push_back(model_row(OP_INSERT, 8'd2, -32'sd1, 32'sd0));
        directed_rows.push_back(model_row(OP_SEARCH, 8'd0, 32'sd0, -32'sd1));
        directed_rows.push_back(fixed_row(OP_SPARE_MID, 8'd2, 32'sd0, 32'sd0, ST_BADPOS, 32'sd0,
                                          8'd3));
        directed_rows.push_back(fixed_row(OP_CLEAR, 8'd0, 32'sd0, 32'sd0, ST_OK, 32'sd0, 8'd0));
        directed_rows.push_back(fixed_row(OP_READ, 8'd1, 32'sd0, 32'sd0, ST_EMPTY, 32'sd0, 8'd0));

        mix = MIX_GROW;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].want,
                         1'b0);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            calm = (k >= RANDOM_ITEMS - CALM_ITEMS);
            if (k == HOLD_AT) hold_request <= 1'b1;
            if (k == RANDOM_ITEMS - CALM_ITEMS) calm_tail <= 1'b1;
            if (k < 260) begin
                mix = MIX_GROW;
            end else if (k < 420) begin
                mix = MIX_SHRINK;
            end else if (k % 100 == 0) begin
                mix = mix_t'($urandom_range(2, 0));
            end
            send_request(make_request(mix), 1'b0, '0, calm);
        end
        s_valid <= 1'b0;

        while (replies_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
